// ----- sv/iset_pkg.sv -----
// Shared types and codes for the integer set core.
package iset_pkg;

    localparam int unsigned KEY_W   = 32;
    localparam int unsigned COUNT_W = 7;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_ERASE  = 2'd1,
        OP_QUERY  = 2'd2
    } op_t;

    typedef struct packed {
        logic [1:0]              req_type;
        logic signed [KEY_W-1:0] key;
    } req_t;

    typedef struct packed {
        logic               was_present;
        logic               full_drop;
        logic [COUNT_W-1:0] entry_count;
    } res_t;

endpackage

// ----- sv/iset_engine.sv -----
// Key memory with clear pass, linear match scan and write-back sequencer.
module iset_engine #(
    parameter int CAPACITY = 64
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start_i,
    input  iset_pkg::req_t  req_i,
    output logic            ready_o,
    output logic            res_valid_o,
    input  logic            res_ready_i,
    output iset_pkg::res_t  res_o
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int WORD_W = iset_pkg::KEY_W + 1;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_WRITE
    } state_t;

    state_t                          state_reg;
    logic [ADDR_W-1:0]               clr_idx_reg;
    logic [CNT_W-1:0]                issue_idx_reg;
    logic                            rd_vld_reg;
    logic [ADDR_W-1:0]               rd_addr_q_reg;
    logic [1:0]                      op_reg;
    logic [iset_pkg::KEY_W-1:0]      key_reg;
    logic                            hit_reg;
    logic [ADDR_W-1:0]               hit_addr_reg;
    logic                            free_found_reg;
    logic [ADDR_W-1:0]               free_addr_reg;
    logic [iset_pkg::COUNT_W-1:0]    count_reg;
    logic [iset_pkg::COUNT_W-1:0]    count_next;

    // Bit KEY_W is the entry valid mark, the rest the stored key.
    logic [WORD_W-1:0]               mem [CAPACITY];
    logic [WORD_W-1:0]               rd_data_reg;
    logic [ADDR_W-1:0]               rd_addr;
    logic                            rd_en;
    logic                            wr_en;
    logic [ADDR_W-1:0]               wr_addr;
    logic [WORD_W-1:0]               wr_data;

    logic                            ins_new;
    logic                            do_ins;
    logic                            do_era;
    logic                            drop;
    logic                            match;
    logic                            last_cmp;

    assign rd_addr  = issue_idx_reg[ADDR_W-1:0];
    assign rd_en    = (state_reg == S_SCAN) && (issue_idx_reg < CNT_W'(CAPACITY));
    assign match    = rd_vld_reg && rd_data_reg[iset_pkg::KEY_W]
                      && (rd_data_reg[iset_pkg::KEY_W-1:0] == key_reg);
    assign last_cmp = rd_vld_reg && (rd_addr_q_reg == ADDR_W'(CAPACITY - 1));

    always_comb begin
        ins_new = 1'b0;
        do_era  = 1'b0;
        case (op_reg)
            iset_pkg::OP_INSERT: ins_new = !hit_reg;
            iset_pkg::OP_ERASE:  do_era  = hit_reg;
            iset_pkg::OP_QUERY:  ins_new = 1'b0;
            default:             ins_new = 1'b0;
        endcase
        do_ins = ins_new && free_found_reg;
        drop   = ins_new && !free_found_reg;
    end

    always_comb begin
        if (do_ins) begin
            count_next = count_reg + iset_pkg::COUNT_W'(1);
        end else if (do_era) begin
            count_next = count_reg - iset_pkg::COUNT_W'(1);
        end else begin
            count_next = count_reg;
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = clr_idx_reg;
        wr_data = '0;
        if (state_reg == S_CLEAR) begin
            wr_en = 1'b1;
        end else if (state_reg == S_WRITE && res_ready_i && (do_ins || do_era)) begin
            wr_en   = 1'b1;
            wr_addr = do_ins ? free_addr_reg : hit_addr_reg;
            wr_data = do_ins ? {1'b1, key_reg} : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            clr_idx_reg    <= '0;
            issue_idx_reg  <= '0;
            rd_vld_reg     <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            count_reg      <= '0;
        end else begin
            case (state_reg)
                S_CLEAR: begin
                    clr_idx_reg <= clr_idx_reg + ADDR_W'(1);
                    if (clr_idx_reg == ADDR_W'(CAPACITY - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start_i) begin
                        op_reg         <= req_i.req_type;
                        key_reg        <= req_i.key;
                        issue_idx_reg  <= '0;
                        rd_vld_reg     <= 1'b0;
                        hit_reg        <= 1'b0;
                        free_found_reg <= 1'b0;
                        state_reg      <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    rd_vld_reg    <= rd_en;
                    rd_addr_q_reg <= rd_addr;
                    if (rd_en) begin
                        issue_idx_reg <= issue_idx_reg + CNT_W'(1);
                    end
                    if (match) begin
                        hit_reg      <= 1'b1;
                        hit_addr_reg <= rd_addr_q_reg;
                        state_reg    <= S_WRITE;
                    end else begin
                        if (rd_vld_reg && !rd_data_reg[iset_pkg::KEY_W] && !free_found_reg) begin
                            free_found_reg <= 1'b1;
                            free_addr_reg  <= rd_addr_q_reg;
                        end
                        if (last_cmp) begin
                            state_reg <= S_WRITE;
                        end
                    end
                end
                S_WRITE: begin
                    rd_vld_reg <= 1'b0;
                    if (res_ready_i) begin
                        count_reg <= count_next;
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign ready_o           = (state_reg == S_IDLE);
    assign res_valid_o       = (state_reg == S_WRITE);
    assign res_o.was_present = hit_reg;
    assign res_o.full_drop   = drop;
    assign res_o.entry_count = count_next;

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start_i |-> state_reg == S_IDLE)
        else $error("request started while engine busy");

    a_drop_absent: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid_o && res_o.full_drop) |-> !res_o.was_present && !wr_en)
        else $error("dropped insert reported a present key or wrote memory");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (CAPACITY > 127) || (int'(count_reg) <= CAPACITY))
        else $error("held count exceeds capacity");

    a_write_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid_o && res_ready_i) |=> state_reg == S_IDLE)
        else $error("engine did not return to idle after a result");

endmodule

// ----- sv/integer_set_insert_erase_lookup_core.sv -----
// Bounded integer set: insert, erase and membership lookup over stream beats.
// The result beat comes later for a higher matching slot k; an absent key scans all
// CAPACITY entries of the key memory.
// Throughput: one request at a time, set by the memory scan reading one entry per cycle.
// A held result stalls input only once a second result waits behind it.
// Reset: aresetn low clears control; a clearing pass then runs with s_tready low while
// every entry's valid mark is written to zero.
module integer_set_insert_erase_lookup_core #(
    parameter int CAPACITY = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] key
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [0] was_present, [1] full_drop, [8:2] entry_count
);

    iset_pkg::req_t req;
    iset_pkg::res_t eng_res;
    logic           eng_ready;
    logic           eng_res_valid;
    logic           res_ready;
    logic           start;

    // Output register: hold the result beat until the sink takes it.
    logic           m_tvalid_reg;
    iset_pkg::res_t m_res_reg;

    assign req.req_type = s_tuser;
    assign req.key      = s_tdata;

    // Accept a beat whenever the engine is idle, regardless of the output side.
    assign s_tready  = eng_ready;
    assign start     = s_tvalid && s_tready;

    // The engine may retire its result when the output register is free or draining.
    assign res_ready = !m_tvalid_reg || m_tready;

    iset_engine #(
        .CAPACITY(CAPACITY)
    ) u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start_i     (start),
        .req_i       (req),
        .ready_o     (eng_ready),
        .res_valid_o (eng_res_valid),
        .res_ready_i (res_ready),
        .res_o       (eng_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            if (eng_res_valid && res_ready) begin
                m_tvalid_reg <= 1'b1;
                m_res_reg    <= eng_res;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, m_res_reg.entry_count, m_res_reg.full_drop, m_res_reg.was_present};

endmodule

// ----- verif/iset_answer_checker.sv -----
`timescale 1ns / 1ps
// Checker for the integer set core: tracks set contents and checks every answer beat.
module iset_answer_checker #(
    parameter int CAPACITY = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] key
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [0] was_present, [1] full_drop, [8:2] entry_count
    output int          fail_count,
    output int          pending_count,
    output int          hit_count,
    output int          drop_count,
    output int          peak_count
);

    logic [iset_pkg::KEY_W-1:0] held_key   [CAPACITY];
    logic                       held_valid [CAPACITY];
    int unsigned                held_total;
    iset_pkg::res_t             pending_answers[$];

    // Apply one request to the tracked set and return the answer it must produce.
    function automatic iset_pkg::res_t apply_request(input logic [1:0] code,
                                                     input logic [iset_pkg::KEY_W-1:0] key);
        iset_pkg::res_t ans;
        int             hit;
        int             slot;
        hit  = -1;
        slot = -1;
        for (int i = 0; i < CAPACITY; i++) begin
            if (hit < 0 && held_valid[i] && held_key[i] == key)
                hit = i;
            if (slot < 0 && !held_valid[i])
                slot = i;
        end
        ans = '0;
        ans.was_present = (hit >= 0);
        case (code)
            iset_pkg::OP_INSERT: begin
                if (hit < 0) begin
                    if (slot >= 0) begin
                        held_key[slot]   = key;
                        held_valid[slot] = 1'b1;
                        held_total++;
                    end else begin
                        ans.full_drop = 1'b1;
                    end
                end
            end
            iset_pkg::OP_ERASE: begin
                if (hit >= 0) begin
                    held_valid[hit] = 1'b0;
                    held_total--;
                end
            end
            default: ;  // lookup and the unused code leave the set alone
        endcase
        ans.entry_count = held_total[iset_pkg::COUNT_W-1:0];
        return ans;
    endfunction

    always @(posedge aclk) begin : watch
        iset_pkg::res_t want;
        iset_pkg::res_t got;
        if (!aresetn) begin
            for (int i = 0; i < CAPACITY; i++)
                held_valid[i] = 1'b0;
            held_total = 0;
            fail_count = 0;
            hit_count  = 0;
            drop_count = 0;
            peak_count = 0;
            pending_answers.delete();
        end else begin
            // A result beat always comes after its request beat, so the request side goes first.
            if (s_tvalid && s_tready) begin
                want = apply_request(s_tuser, s_tdata);
                pending_answers = {pending_answers, want};
                if (want.was_present)
                    hit_count++;
                if (want.full_drop)
                    drop_count++;
                if (int'(held_total) > peak_count)
                    peak_count = int'(held_total);
            end
            if (m_tvalid && m_tready) begin
                got.was_present = m_tdata[0];
                got.full_drop   = m_tdata[1];
                got.entry_count = m_tdata[8:2];
                if (pending_answers.size() == 0) begin
                    $error("answer beat with no request outstanding: tdata %h", m_tdata);
                    fail_count++;
                end else begin
                    want = pending_answers.pop_front();
                    if (got.was_present !== want.was_present) begin
                        $error("was_present: expected %0d, got %0d",
                               want.was_present, got.was_present);
                        fail_count++;
                    end
                    if (got.full_drop !== want.full_drop) begin
                        $error("full_drop: expected %0d, got %0d",
                               want.full_drop, got.full_drop);
                        fail_count++;
                    end
                    if (got.entry_count !== want.entry_count) begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, got.entry_count);
                        fail_count++;
                    end
                end
            end
        end
        pending_count = pending_answers.size();
    end

endmodule

// ----- verif/tb_integer_set_insert_erase_lookup_core.sv -----
`timescale 1ns / 1ps
// Testbench top for the integer set core: request stimulus, answer flow control and verdict.
module tb_integer_set_insert_erase_lookup_core;

    localparam int CAPACITY   = 64;
    localparam int POOL_SIZE  = 48;
    localparam int RECENT_MAX = 96;
    localparam int PHASE_REQS = 358;
    localparam int LONG_HOLD  = 300;

    // The request code the block does not define; it must behave as a lookup.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Request mixes for the random episodes.
    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_BALANCED
    } mix_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [31:0] key
    logic [1:0]  s_tuser;   // [1:0] req_type
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [0] was_present, [1] full_drop, [8:2] entry_count

    int fail_count;
    int pending_count;
    int hit_count;
    int drop_count;
    int peak_count;

    // Flow control knobs, changed per phase by the stimulus process.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_now       = 1'b0;

    int          reqs_by_code[4];
    logic [31:0] key_pool[POOL_SIZE];
    logic [31:0] recent_keys[$];

    integer_set_insert_erase_lookup_core #(
        .CAPACITY (CAPACITY)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    iset_answer_checker #(
        .CAPACITY (CAPACITY)
    ) u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .hit_count     (hit_count),
        .drop_count    (drop_count),
        .peak_count    (peak_count)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Drive one request beat: idle at random first, then hold the beat until taken.
    task automatic send_req(input logic [1:0] code, input logic [31:0] key);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = code;
        s_tdata  = key;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        reqs_by_code[code]++;
        // Remember inserted keys so later erases and lookups mostly hit.
        if (code == iset_pkg::OP_INSERT) begin
            recent_keys = {recent_keys, key};
            if (recent_keys.size() > RECENT_MAX)
                void'(recent_keys.pop_front());
        end
    endtask

    function automatic logic [1:0] pick_code(input mix_t mix);
        int roll;
        int ins_cut;
        int era_cut;
        roll = $urandom_range(99);
        case (mix)
            MIX_FILL:  begin ins_cut = 83; era_cut = 88; end
            MIX_DRAIN: begin ins_cut = 13; era_cut = 85; end
            default:   begin ins_cut = 38; era_cut = 68; end
        endcase
        if (roll < 3)
            return OP_UNUSED;
        else if (roll < ins_cut)
            return iset_pkg::OP_INSERT;
        else if (roll < era_cut)
            return iset_pkg::OP_ERASE;
        return iset_pkg::OP_QUERY;
    endfunction

    // Mostly reuse keys so the set sees hits; fresh random keys push it toward full.
    function automatic logic [31:0] pick_key(input mix_t mix);
        int roll;
        int fresh_cut;
        roll      = $urandom_range(99);
        fresh_cut = (mix == MIX_FILL) ? 50 : 25;
        if (roll < 10) begin
            case ($urandom_range(3))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        if (roll < fresh_cut || recent_keys.size() == 0)
            return $urandom();
        if (roll < 60)
            return key_pool[$urandom_range(POOL_SIZE - 1)];
        return recent_keys[$urandom_range(recent_keys.size() - 1)];
    endfunction

    // Answer side: random stalls, plus one long hold-off counted here on request.
    initial begin : answer_flow
        int hold_left;
        bit hold_used;
        hold_left = 0;
        hold_used = 1'b0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_now && !hold_used) begin
                hold_left = LONG_HOLD;
                hold_used = 1'b1;
            end
            if (hold_left > 0) begin
                m_tready = 1'b0;
                hold_left--;
            end else begin
                m_tready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin : stimulus
        int   left;
        int   len;
        bit   first;
        mix_t mix;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = iset_pkg::OP_QUERY;
        for (int i = 0; i < 4; i++)
            reqs_by_code[i] = 0;
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = $urandom();

        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: empty set, key extremes, duplicates, absent erase, unused code.
        send_req(iset_pkg::OP_QUERY,  32'h0000_0000);
        send_req(iset_pkg::OP_ERASE,  32'h0000_0000);
        send_req(iset_pkg::OP_INSERT, 32'h8000_0000);
        send_req(iset_pkg::OP_INSERT, 32'h7FFF_FFFF);
        send_req(iset_pkg::OP_INSERT, 32'h0000_0000);
        send_req(iset_pkg::OP_INSERT, 32'hFFFF_FFFF);
        send_req(iset_pkg::OP_INSERT, 32'h0000_0001);
        send_req(iset_pkg::OP_INSERT, 32'h7FFF_FFFF);
        send_req(iset_pkg::OP_QUERY,  32'h8000_0000);
        send_req(iset_pkg::OP_QUERY,  32'h8000_0001);
        send_req(iset_pkg::OP_ERASE,  32'h0000_0000);
        send_req(iset_pkg::OP_ERASE,  32'h0000_0000);
        send_req(OP_UNUSED, 32'h0000_0001);
        send_req(OP_UNUSED, 32'h0000_0000);
        // Reinsert lands in the slot just freed.
        send_req(iset_pkg::OP_INSERT, 32'h0000_0000);
        send_req(iset_pkg::OP_QUERY,  32'h0000_0000);
        send_req(iset_pkg::OP_ERASE,  32'h8000_0000);
        send_req(iset_pkg::OP_ERASE,  32'hFFFF_FFFF);
        send_req(iset_pkg::OP_ERASE,  32'h7FFF_FFFF);
        send_req(iset_pkg::OP_ERASE,  32'h0000_0001);
        send_req(iset_pkg::OP_ERASE,  32'h0000_0000);
        send_req(iset_pkg::OP_QUERY,  32'h5555_5555);
        send_req(iset_pkg::OP_INSERT, 32'hAAAA_AAAA);
        send_req(iset_pkg::OP_ERASE,  32'hAAAA_AAAA);

        // Random phases: no idling, sender idle, receiver stalling, both.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            // Back-pressure the answers while requests keep coming at full rate.
            if (phase == 0)
                hold_now = 1'b1;
            left  = PHASE_REQS;
            first = 1'b1;
            while (left > 0) begin
                // Open each phase by filling the set so full-drop inserts occur.
                if (first) begin
                    mix = MIX_FILL;
                    len = 120;
                end else begin
                    mix = mix_t'($urandom_range(2));
                    len = $urandom_range(20, 60);
                end
                first = 1'b0;
                for (int n = 0; n < len && left > 0; n++) begin
                    send_req(pick_code(mix), pick_key(mix));
                    left--;
                end
            end
        end
        s_tvalid = 1'b0;

        // Drain outstanding answers, then allow one full scan for stray beats.
        while (pending_count != 0)
            @(negedge aclk);
        repeat (CAPACITY + 8) @(negedge aclk);

        $display("Ran %0d inserts, %0d erases, %0d lookups and %0d unused-code requests.",
                 reqs_by_code[iset_pkg::OP_INSERT], reqs_by_code[iset_pkg::OP_ERASE],
                 reqs_by_code[iset_pkg::OP_QUERY], reqs_by_code[OP_UNUSED]);
        $display("Saw %0d hits and %0d dropped inserts; set held up to %0d keys.",
                 hit_count, drop_count, peak_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
